>>> sv/smpq_pkg.sv
// Package for the sorted min priority queue: word types, codes and widths.
`default_nettype none
package smpq_pkg;

    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 5;
    localparam int STATUS_W    = 2;
    localparam int DEPTH_DFLT  = 16;

    localparam logic [COUNT_W-1:0] CAP_RESET = COUNT_W'(16);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                      cmd;
        logic signed [VALUE_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] removed_value;
        logic [COUNT_W-1:0]        live_count;
    } t_out_word;

    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage
`default_nettype wire

>>> sv/smpq_cell.sv
// One slot of the sorted chain: holds a value, shifts left on delete, opens on insert.
`default_nettype none
module smpq_cell (
    input  wire                                   i_clk,
    input  wire smpq_pkg::t_cell_ctl              i_ctl,
    input  wire signed [smpq_pkg::VALUE_W-1:0]    i_value,
    input  wire                                   i_live,
    input  wire                                   i_left_take,
    input  wire signed [smpq_pkg::VALUE_W-1:0]    i_left_val,
    input  wire signed [smpq_pkg::VALUE_W-1:0]    i_right_val,
    output logic                                  o_take,
    output logic signed [smpq_pkg::VALUE_W-1:0]   o_val
);

    logic signed [smpq_pkg::VALUE_W-1:0] r_val;

    // new value goes at or before this slot
    assign o_take = !i_live || (r_val > i_value);
    assign o_val  = r_val;

    always_ff @(posedge i_clk) begin
        if (i_ctl.del) begin
            r_val <= i_right_val;
        end else if (i_ctl.ins) begin
            if (i_left_take) begin
                r_val <= i_left_val;
            end else if (o_take) begin
                r_val <= i_value;
            end
        end
    end

endmodule
`default_nettype wire

>>> sv/sorted_min_priority_queue_core.sv
// Sorted min priority queue: a chain of value cells with a live count and output register.
// The result word of an accepted word is captured in the output register on its accepting edge.
// Throughput: one insert or delete per cycle while not stalled; each cell does one compare
// against the broadcast value and a neighbor shift, so a word may follow in the next cycle.
// Reset: live count cleared, capacity set to 16, output empty; cell values are not cleared.
`default_nettype none
module sorted_min_priority_queue_core #(
    parameter int DEPTH = smpq_pkg::DEPTH_DFLT
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire smpq_pkg::t_in_word          i_in_word,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output smpq_pkg::t_out_word              o_out_word,
    input  wire                              i_cfg_we,
    input  wire [smpq_pkg::COUNT_W-1:0]      i_cfg_wdata
);

    localparam int DW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (DW > smpq_pkg::COUNT_W) ? DW : smpq_pkg::COUNT_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    logic [smpq_pkg::COUNT_W-1:0] r_count, n_count;
    logic [smpq_pkg::COUNT_W-1:0] r_cap;
    logic                         r_out_valid;
    smpq_pkg::t_out_word          r_out_word, n_out_word;

    logic                         accept;
    logic                         full;
    logic                         empty;
    logic [CMP_W-1:0]             count_w;
    smpq_pkg::t_cell_ctl          ctl;

    logic                                 take [DEPTH];
    logic signed [smpq_pkg::VALUE_W-1:0]  val  [DEPTH];
    logic                                 live [DEPTH];

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign count_w = CMP_W'(r_count);
    assign full    = (r_count >= r_cap) || (count_w >= DEPTH_C);
    assign empty   = (r_count == '0);

    assign ctl.ins = accept && (i_in_word.cmd == smpq_pkg::CMD_INSERT) && !full;
    assign ctl.del = accept && (i_in_word.cmd == smpq_pkg::CMD_DELETE) && !empty;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            assign live[gi] = CMP_W'(gi) < count_w;
            if (gi == 0) begin : g_head
                smpq_cell u_cell (
                    .i_clk       (i_clk),
                    .i_ctl       (ctl),
                    .i_value     (i_in_word.value),
                    .i_live      (live[gi]),
                    .i_left_take (1'b0),
                    .i_left_val  (i_in_word.value),
                    .i_right_val ((DEPTH > 1) ? val[(DEPTH > 1) ? 1 : 0] : val[0]),
                    .o_take      (take[gi]),
                    .o_val       (val[gi])
                );
            end else if (gi == DEPTH - 1) begin : g_tail
                smpq_cell u_cell (
                    .i_clk       (i_clk),
                    .i_ctl       (ctl),
                    .i_value     (i_in_word.value),
                    .i_live      (live[gi]),
                    .i_left_take (take[gi-1]),
                    .i_left_val  (val[gi-1]),
                    .i_right_val (val[gi]),
                    .o_take      (take[gi]),
                    .o_val       (val[gi])
                );
            end else begin : g_mid
                smpq_cell u_cell (
                    .i_clk       (i_clk),
                    .i_ctl       (ctl),
                    .i_value     (i_in_word.value),
                    .i_live      (live[gi]),
                    .i_left_take (take[gi-1]),
                    .i_left_val  (val[gi-1]),
                    .i_right_val (val[gi+1]),
                    .o_take      (take[gi]),
                    .o_val       (val[gi])
                );
            end
        end
    endgenerate

    always_comb begin
        n_count                  = r_count;
        n_out_word.status        = smpq_pkg::ST_DONE;
        n_out_word.removed_value = '0;
        if (i_in_word.cmd == smpq_pkg::CMD_INSERT) begin
            if (full) begin
                n_out_word.status = smpq_pkg::ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (empty) begin
                n_out_word.status = smpq_pkg::ST_EMPTY;
            end else begin
                n_count                  = r_count - 1'b1;
                n_out_word.removed_value = val[0];
            end
        end
        n_out_word.live_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cap       <= smpq_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_word <= n_out_word;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count_w <= DEPTH_C)
        else $error("live count above depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.ins |=> r_count == $past(r_count) + 1'b1)
        else $error("insert did not grow count");

    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.status == smpq_pkg::ST_EMPTY) |->
            (r_out_word.live_count == '0 && r_out_word.removed_value == '0))
        else $error("empty status with live entries or value");

    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_word.cmd == smpq_pkg::CMD_INSERT && full) |=> $stable(r_count))
        else $error("refused insert changed count");

endmodule
`default_nettype wire

>>> test/sorted_min_priority_queue_core_tb.sv
// Testbench for the sorted min priority queue core: directed and random words checked against a predictor.
`default_nettype none
module sorted_min_priority_queue_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = smpq_pkg::DEPTH_DFLT;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic signed [smpq_pkg::VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [smpq_pkg::VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    smpq_pkg::t_in_word            i_in_word = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    smpq_pkg::t_out_word           o_out_word;
    logic                          i_cfg_we = 1'b0;
    logic [smpq_pkg::COUNT_W-1:0]  i_cfg_wdata = '0;

    logic signed [smpq_pkg::VALUE_W-1:0] held_values[$];
    logic [smpq_pkg::COUNT_W-1:0]        queue_capacity = smpq_pkg::CAP_RESET;
    smpq_pkg::t_out_word                 expected_results[$];
    int                                  mismatch_count = 0;
    int                                  cycle_count = 0;
    int                                  idle_pct = 0;
    int                                  stall_pct = 0;

    sorted_min_priority_queue_core #(
        .DEPTH (QUEUE_DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sorted_min_priority_queue_core test failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic smpq_pkg::t_out_word predict_queue_op(input smpq_pkg::t_in_word w);
        smpq_pkg::t_out_word res;
        int limit;
        int pos;
        res = '0;
        res.status = smpq_pkg::ST_DONE;
        limit = (queue_capacity < QUEUE_DEPTH) ? queue_capacity : QUEUE_DEPTH;
        if (w.cmd == smpq_pkg::CMD_INSERT) begin
            if (held_values.size() >= limit) begin
                res.status = smpq_pkg::ST_FULL;
            end else begin
                pos = held_values.size();
                for (int i = 0; i < held_values.size(); i++) begin
                    if (held_values[i] > w.value) begin
                        pos = i;
                        break;
                    end
                end
                held_values.insert(pos, w.value);
            end
        end else begin
            if (held_values.size() == 0) begin
                res.status = smpq_pkg::ST_EMPTY;
            end else begin
                res.removed_value = held_values.pop_front();
            end
        end
        res.live_count = smpq_pkg::COUNT_W'(held_values.size());
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    endtask

    always @(negedge i_clk) begin
        smpq_pkg::t_out_word want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result word %h with nothing expected", o_out_word));
            end else begin
                want = expected_results.pop_front();
                if (o_out_word.status !== want.status)
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              o_out_word.status, want.status));
                if (o_out_word.removed_value !== want.removed_value)
                    report_mismatch($sformatf("removed_value got %h expected %h",
                                              o_out_word.removed_value, want.removed_value));
                if (o_out_word.live_count !== want.live_count)
                    report_mismatch($sformatf("live_count got %0d expected %0d",
                                              o_out_word.live_count, want.live_count));
            end
        end
    end

    task automatic idle_after_word();
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic send_word(input logic cmd,
                             input logic signed [smpq_pkg::VALUE_W-1:0] value);
        smpq_pkg::t_in_word w;
        logic taken;
        w.cmd = cmd;
        w.value = value;
        i_in_valid <= 1'b1;
        i_in_word <= w;
        taken = 1'b0;
        while (taken !== 1'b1) begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end
        expected_results.push_back(predict_queue_op(w));
        idle_after_word();
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [smpq_pkg::COUNT_W-1:0] cap);
        wait_for_results();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        queue_capacity = cap;
    endtask

    function automatic logic signed [smpq_pkg::VALUE_W-1:0] pick_value();
        logic signed [smpq_pkg::VALUE_W-1:0] v;
        case ($urandom_range(3))
            0: begin
                v = $urandom_range(8);
                v = v - 4;
            end
            1: begin
                case ($urandom_range(3))
                    0: v = VALUE_MIN;
                    1: v = VALUE_MAX;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic test_empty_and_order();
        send_word(smpq_pkg::CMD_DELETE, VALUE_MAX);
        send_word(smpq_pkg::CMD_INSERT, VALUE_MAX);
        send_word(smpq_pkg::CMD_INSERT, VALUE_MIN);
        send_word(smpq_pkg::CMD_INSERT, 0);
        send_word(smpq_pkg::CMD_INSERT, -1);
        send_word(smpq_pkg::CMD_INSERT, 0);
        repeat (6) send_word(smpq_pkg::CMD_DELETE, 0);
    endtask

    task automatic test_full_refusal();
        write_capacity(2);
        send_word(smpq_pkg::CMD_INSERT, 7);
        send_word(smpq_pkg::CMD_INSERT, -3);
        send_word(smpq_pkg::CMD_INSERT, 5);
    endtask

    task automatic test_capacity_lowered();
        write_capacity(1);
        send_word(smpq_pkg::CMD_INSERT, 9);
        send_word(smpq_pkg::CMD_DELETE, 0);
        send_word(smpq_pkg::CMD_INSERT, 9);
        send_word(smpq_pkg::CMD_DELETE, 0);
        send_word(smpq_pkg::CMD_INSERT, 9);
    endtask

    task automatic test_capacity_zero();
        write_capacity(0);
        send_word(smpq_pkg::CMD_INSERT, 1);
        send_word(smpq_pkg::CMD_DELETE, 0);
        send_word(smpq_pkg::CMD_DELETE, 0);
    endtask

    task automatic run_random_phase(input logic [smpq_pkg::COUNT_W-1:0] cap, input int mode,
                                    input int count);
        int run_left;
        int insert_pct;
        run_left = 0;
        insert_pct = 50;
        write_capacity(cap);
        case (mode)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 64; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 64; end
            default: begin idle_pct = 27; stall_pct = 27; end
        endcase
        for (int n = 0; n < count; n++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(60, 10);
                case ($urandom_range(2))
                    0: insert_pct = 80;
                    1: insert_pct = 20;
                    default: insert_pct = 50;
                endcase
            end
            run_left--;
            if ($urandom_range(99) < 1) wait_for_results();
            if ($urandom_range(99) < insert_pct)
                send_word(smpq_pkg::CMD_INSERT, pick_value());
            else
                send_word(smpq_pkg::CMD_DELETE, $urandom);
        end
        idle_pct = 0;
        stall_pct = 0;
    endtask

    task automatic test_random();
        logic [smpq_pkg::COUNT_W-1:0] caps[8];
        caps = '{5'd16, 5'd31, 5'd4, 5'd1, 5'd0, 5'd20, 5'd16, 5'd16};
        caps[6] = smpq_pkg::COUNT_W'($urandom_range(31, 1));
        for (int p = 0; p < 8; p++) begin
            run_random_phase(caps[p], p % 4, (caps[p] == 0) ? 120 : 260);
        end
    endtask

    initial begin
        held_values.delete();
        queue_capacity = smpq_pkg::CAP_RESET;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_order();
        test_full_refusal();
        test_capacity_lowered();
        test_capacity_zero();
        test_random();

        wait_for_results();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("sorted_min_priority_queue_core test passed");
        end else begin
            $display("sorted_min_priority_queue_core test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
